@@ sv/weighted_moment_accumulator_assert.svh @@
// Assertion macros shared by the checker of the weighted moment accumulator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef WEIGHTED_MOMENT_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_MOMENT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wma_pkg.sv @@
// Package of the weighted moment accumulator: widths, limits, codes and state types.
// Depends on nothing; every other file of the block but the assertion macro header imports it.
`timescale 1ns / 1ps

package wma_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int TOTAL_W    = 32;
    localparam int MEAN1_W    = 16;
    localparam int MEANSQ_W   = 31;
    localparam int MEANX_W    = 32;
    localparam int MEAN_MAG_W = 32;
    localparam int MEAN_S_W   = MEAN_MAG_W + 1;
    localparam int NUM_W_DEF  = 2 * MEAN_MAG_W + 1;

    localparam logic [TOTAL_W-1:0] LIM1_POS  = 32'h0000_7FFF;
    localparam logic [TOTAL_W-1:0] LIM1_NEG  = 32'h0000_8000;
    localparam logic [TOTAL_W-1:0] LIMSQ_POS = 32'h7FFF_FFFF;
    localparam logic [TOTAL_W-1:0] LIMSQ_NEG = 32'h0000_0000;
    localparam logic [TOTAL_W-1:0] LIMX_POS  = 32'h7FFF_FFFF;
    localparam logic [TOTAL_W-1:0] LIMX_NEG  = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTIED,
        ST_REM_REFUSED,
        ST_ADD_REFUSED
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TERM,
        S_MUL,
        S_COMB,
        S_CHK,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        CLS_FIRST,
        CLS_SQUARE,
        CLS_CROSS
    } t_cls;

    typedef struct packed {
        logic busy;
        logic over;
    } t_div_stat;

endpackage

@@ sv/wma_if.sv @@
// Handshake interfaces of the weighted moment accumulator: hit channel and result channel.
// Depends on wma_pkg for widths and the status code type.
`timescale 1ns / 1ps

interface wma_hit_if import wma_pkg::*; #(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [POS_BITS-1:0]    pos_x;
    logic signed [POS_BITS-1:0]    pos_y;
    logic signed [POS_BITS-1:0]    pos_z;
    logic        [WEIGHT_BITS-1:0] weight;

    modport source (output valid, kind, pos_x, pos_y, pos_z, weight, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, pos_z, weight, output ready);
endinterface

interface wma_res_if import wma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    t_status                    status;
    logic        [TOTAL_W-1:0]  total_weight;
    logic signed [MEAN1_W-1:0]  mean_x;
    logic signed [MEAN1_W-1:0]  mean_y;
    logic signed [MEAN1_W-1:0]  mean_z;
    logic        [MEANSQ_W-1:0] mean_xx;
    logic        [MEANSQ_W-1:0] mean_yy;
    logic        [MEANSQ_W-1:0] mean_zz;
    logic signed [MEANX_W-1:0]  mean_xy;
    logic signed [MEANX_W-1:0]  mean_yz;
    logic signed [MEANX_W-1:0]  mean_zx;

    modport source (output valid, status, total_weight, mean_x, mean_y, mean_z,
                    mean_xx, mean_yy, mean_zz, mean_xy, mean_yz, mean_zx,
                    input ready);
    modport sink   (input valid, status, total_weight, mean_x, mean_y, mean_z,
                    mean_xx, mean_yy, mean_zz, mean_xy, mean_yz, mean_zx,
                    output ready);
endinterface

@@ sv/weighted_moment_accumulator.sv @@
// Each accepted hit runs nine updates, one per mean: first moments, then squares, then cross terms.
// Each update runs two bit-serial multipliers, the longer over the 32-bit total, then the bit-serial divider.
// Refused hits and hits that empty the track skip the updates and go straight to the result register.
// One hit is in work at a time; the next is accepted once the result is registered,
// which waits while an earlier result is stalled on the output.
// Reset (synchronous, active low) clears the total and all means and empties the output.
`timescale 1ns / 1ps

module weighted_moment_accumulator import wma_pkg::*; #(
    parameter int POS_BITS    = POS_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wma_hit_if.sink   i_hit,
    wma_res_if.source o_res
);

    localparam int TERM_W  = 2 * POS_BITS;
    localparam int TMAG_W  = TERM_W - 1;
    localparam int A_W     = MEAN_MAG_W + TOTAL_W;
    localparam int B_W     = TMAG_W + WEIGHT_BITS;
    localparam int NUM_W   = ((A_W > B_W) ? A_W : B_W) + 1;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    t_state r_state, n_state;

    logic                          r_kind;
    logic signed [POS_BITS-1:0]    r_pos [3];
    logic        [WEIGHT_BITS-1:0] r_w;
    logic        [TOTAL_W-1:0]     r_nt;
    t_status                       r_status;
    logic        [1:0]             r_axis;
    t_cls                          r_cls;

    logic        [TOTAL_W-1:0]     r_total;
    logic signed [MEAN1_W-1:0]     r_m1  [3];
    logic        [MEANSQ_W-1:0]    r_msq [3];
    logic signed [MEANX_W-1:0]     r_mx  [3];

    logic                  r_sa;
    logic                  r_sb;
    logic [NUM_W-1:0]      r_num;
    logic                  r_sr;

    logic                       r_ovalid;
    t_status                    r_o_status;
    logic        [TOTAL_W-1:0]  r_o_total;
    logic signed [MEAN1_W-1:0]  r_o_m1  [3];
    logic        [MEANSQ_W-1:0] r_o_msq [3];
    logic signed [MEANX_W-1:0]  r_o_mx  [3];

    logic in_ready, accept, mul_start, div_start, out_load;

    logic [TOTAL_W:0]   pre_sum, pre_diff, pre_w;
    logic               pre_rem_ref, pre_add_ref, pre_empty;
    logic [TOTAL_W-1:0] pre_nt;
    t_status            pre_status;

    always_comb begin
        pre_w       = (TOTAL_W+1)'(i_hit.weight);
        pre_sum     = {1'b0, r_total} + pre_w;
        pre_diff    = {1'b0, r_total} - pre_w;
        pre_rem_ref = i_hit.kind && pre_diff[TOTAL_W];
        pre_add_ref = !i_hit.kind && pre_sum[TOTAL_W];
        pre_nt      = i_hit.kind ? pre_diff[TOTAL_W-1:0] : pre_sum[TOTAL_W-1:0];
        pre_empty   = (pre_nt == '0);
        if (pre_rem_ref) begin
            pre_status = ST_REM_REFUSED;
        end else if (pre_add_ref) begin
            pre_status = ST_ADD_REFUSED;
        end else if (pre_empty) begin
            pre_status = ST_EMPTIED;
        end else begin
            pre_status = ST_OK;
        end
    end

    logic [1:0]                 axis_nx;
    logic signed [POS_BITS-1:0] p_i, p_j, p_sel;
    logic signed [TERM_W-1:0]   prod, term, tabs;
    logic signed [MEAN_S_W-1:0] mean_s, mabs;

    always_comb begin
        axis_nx = (r_axis == AXIS_LAST) ? 2'd0 : r_axis + 2'd1;
        p_i     = r_pos[r_axis];
        p_j     = r_pos[axis_nx];
        p_sel   = (r_cls == CLS_SQUARE) ? p_i : p_j;
        prod    = p_i * p_sel;
        term    = (r_cls == CLS_FIRST) ? {{POS_BITS{p_i[POS_BITS-1]}}, p_i} : prod;
        tabs    = term[TERM_W-1] ? -term : term;
        case (r_cls)
            CLS_FIRST: begin
                mean_s = {{(MEAN_S_W-MEAN1_W){r_m1[r_axis][MEAN1_W-1]}}, r_m1[r_axis]};
            end
            CLS_SQUARE: begin
                mean_s = {{(MEAN_S_W-MEANSQ_W){1'b0}}, r_msq[r_axis]};
            end
            CLS_CROSS: begin
                mean_s = {{(MEAN_S_W-MEANX_W){r_mx[r_axis][MEANX_W-1]}}, r_mx[r_axis]};
            end
            default: begin
                mean_s = '0;
            end
        endcase
        mabs = mean_s[MEAN_S_W-1] ? -mean_s : mean_s;
    end

    logic             mul_a_busy, mul_b_busy;
    logic [A_W-1:0]   prod_a;
    logic [B_W-1:0]   prod_b;

    wma_serial_mul #(
        .MC_W (MEAN_MAG_W),
        .ML_W (TOTAL_W)
    ) u_mul_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mabs[MEAN_MAG_W-1:0]),
        .i_mplier  (r_total),
        .o_busy    (mul_a_busy),
        .o_product (prod_a)
    );

    wma_serial_mul #(
        .MC_W (TMAG_W),
        .ML_W (WEIGHT_BITS)
    ) u_mul_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (tabs[TMAG_W-1:0]),
        .i_mplier  (r_w),
        .o_busy    (mul_b_busy),
        .o_product (prod_b)
    );

    logic [NUM_W-1:0] a_e, b_e, c_sum, c_dba;
    logic [NUM_W:0]   c_dab;
    logic             a_ge;

    always_comb begin
        a_e   = NUM_W'(prod_a);
        b_e   = NUM_W'(prod_b);
        c_sum = a_e + b_e;
        c_dab = {1'b0, a_e} - {1'b0, b_e};
        c_dba = b_e - a_e;
        a_ge  = !c_dab[NUM_W];
    end

    t_div_stat          div_stat;
    logic [TOTAL_W-1:0] quot;

    wma_serial_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_div   (r_nt),
        .o_stat  (div_stat),
        .o_quot  (quot)
    );

    logic [TOTAL_W-1:0] lim, mag;
    logic               sat;
    logic [TOTAL_W:0]   val;
    logic               wb_last;

    always_comb begin
        case (r_cls)
            CLS_FIRST:  lim = r_sr ? LIM1_NEG  : LIM1_POS;
            CLS_SQUARE: lim = r_sr ? LIMSQ_NEG : LIMSQ_POS;
            CLS_CROSS:  lim = r_sr ? LIMX_NEG  : LIMX_POS;
            default:    lim = '0;
        endcase
        sat     = div_stat.over || (quot > lim);
        mag     = sat ? lim : quot;
        val     = r_sr ? -{1'b0, mag} : {1'b0, mag};
        wb_last = (r_axis == AXIS_LAST) && (r_cls == CLS_CROSS);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_hit.valid) begin
                    if (pre_status == ST_OK) begin
                        n_state = S_TERM;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TERM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                if (!mul_a_busy && !mul_b_busy) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!div_stat.busy) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                n_state = wb_last ? S_DONE : S_TERM;
            end
            S_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = (r_state == S_IDLE);
        mul_start = (r_state == S_TERM);
        div_start = (r_state == S_CHK);
        out_load  = (r_state == S_DONE) && (!r_ovalid || o_res.ready);
        accept    = in_ready && i_hit.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int k = 0; k < 3; k++) begin
                r_m1[k]  <= '0;
                r_msq[k] <= '0;
                r_mx[k]  <= '0;
            end
        end else if (accept && (pre_status == ST_EMPTIED)) begin
            r_total <= '0;
            for (int k = 0; k < 3; k++) begin
                r_m1[k]  <= '0;
                r_msq[k] <= '0;
                r_mx[k]  <= '0;
            end
        end else if (r_state == S_WB) begin
            case (r_cls)
                CLS_FIRST:  r_m1[r_axis]  <= val[MEAN1_W-1:0];
                CLS_SQUARE: r_msq[r_axis] <= val[MEANSQ_W-1:0];
                CLS_CROSS:  r_mx[r_axis]  <= val[MEANX_W-1:0];
                default:    r_mx[r_axis]  <= r_mx[r_axis];
            endcase
            if (wb_last) begin
                r_total <= r_nt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_hit.kind;
            r_pos[0] <= i_hit.pos_x;
            r_pos[1] <= i_hit.pos_y;
            r_pos[2] <= i_hit.pos_z;
            r_w      <= i_hit.weight;
            r_nt     <= pre_nt;
            r_status <= pre_status;
            r_axis   <= '0;
            r_cls    <= CLS_FIRST;
        end else if (r_state == S_WB) begin
            if (r_axis == AXIS_LAST) begin
                r_axis <= '0;
                r_cls  <= (r_cls == CLS_FIRST) ? CLS_SQUARE : CLS_CROSS;
            end else begin
                r_axis <= axis_nx;
            end
        end
        if (r_state == S_TERM) begin
            r_sa   <= mean_s[MEAN_S_W-1];
            r_sb   <= term[TERM_W-1] ^ r_kind;
        end
        if (r_state == S_COMB) begin
            if (r_sa == r_sb) begin
                r_num <= c_sum;
                r_sr  <= r_sa;
            end else if (a_ge) begin
                r_num <= c_dab[NUM_W-1:0];
                r_sr  <= r_sa;
            end else begin
                r_num <= c_dba;
                r_sr  <= r_sb;
            end
        end
        if (out_load) begin
            r_o_status <= r_status;
            r_o_total  <= r_total;
            r_o_m1     <= r_m1;
            r_o_msq    <= r_msq;
            r_o_mx     <= r_mx;
        end
    end

    assign i_hit.ready        = in_ready;
    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_o_status;
    assign o_res.total_weight = r_o_total;
    assign o_res.mean_x       = r_o_m1[0];
    assign o_res.mean_y       = r_o_m1[1];
    assign o_res.mean_z       = r_o_m1[2];
    assign o_res.mean_xx      = r_o_msq[0];
    assign o_res.mean_yy      = r_o_msq[1];
    assign o_res.mean_zz      = r_o_msq[2];
    assign o_res.mean_xy      = r_o_mx[0];
    assign o_res.mean_yz      = r_o_mx[1];
    assign o_res.mean_zx      = r_o_mx[2];

endmodule

@@ sv/wma_serial_mul.sv @@
// Bit-serial shift-and-add multiplier of unsigned operands, one multiplier bit per cycle.
// Depends on wma_pkg for default widths.
`timescale 1ns / 1ps

module wma_serial_mul import wma_pkg::*; #(
    parameter int MC_W = MEAN_MAG_W,
    parameter int ML_W = TOTAL_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MC_W-1:0]      i_mcand,
    input  logic [ML_W-1:0]      i_mplier,
    output logic                 o_busy,
    output logic [MC_W+ML_W-1:0] o_product
);

    localparam int CNT_W = (ML_W > 1) ? $clog2(ML_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ML_W - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [MC_W-1:0]      r_mc;
    logic [MC_W+ML_W-1:0] r_prod;
    logic [MC_W:0]        n_sum;

    assign n_sum = {1'b0, r_prod[MC_W+ML_W-1:ML_W]}
                 + (r_prod[0] ? {1'b0, r_mc} : {(MC_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc   <= i_mcand;
            r_prod <= {{MC_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_prod <= {n_sum, r_prod[ML_W-1:1]};
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_prod;

endmodule

@@ sv/wma_serial_div.sv @@
// Radix-2 restoring divider: wide numerator by the 32-bit total, one quotient bit per cycle.
// Flags a quotient that does not fit 32 bits. Depends on wma_pkg.
`timescale 1ns / 1ps

module wma_serial_div import wma_pkg::*; #(
    parameter int NUM_W = NUM_W_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [TOTAL_W-1:0] i_div,
    output t_div_stat          o_stat,
    output logic [TOTAL_W-1:0] o_quot
);

    localparam int HI_W  = NUM_W - TOTAL_W;
    localparam int CNT_W = $clog2(TOTAL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOTAL_W - 1);

    logic               r_busy;
    logic               r_over;
    logic [CNT_W-1:0]   r_cnt;
    logic [TOTAL_W-1:0] r_rem;
    logic [TOTAL_W-1:0] r_q;
    logic [HI_W-1:0]    n_hi;
    logic               n_over;
    logic [TOTAL_W:0]   n_trial;
    logic [TOTAL_W:0]   n_diff;
    logic               n_ge;

    assign n_hi    = i_num[NUM_W-1:TOTAL_W];
    assign n_over  = n_hi >= HI_W'(i_div);
    assign n_trial = {r_rem, r_q[TOTAL_W-1]};
    assign n_diff  = n_trial - {1'b0, i_div};
    assign n_ge    = !n_diff[TOTAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_over <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !n_over;
            r_over <= n_over;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= n_hi[TOTAL_W-1:0];
            r_q   <= i_num[TOTAL_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[TOTAL_W-1:0] : n_trial[TOTAL_W-1:0];
            r_q   <= {r_q[TOTAL_W-2:0], n_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.over = r_over;
    assign o_quot      = r_q;

endmodule

@@ sv/wma_checker.sv @@
// Port-level checker of the weighted moment accumulator, bound to the top level.
// Depends on wma_pkg and the assertion macros in weighted_moment_accumulator_assert.svh.
`timescale 1ns / 1ps
`include "weighted_moment_accumulator_assert.svh"

module wma_checker import wma_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_hit_valid,
    input logic                       i_hit_ready,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input t_status                    i_status,
    input logic        [TOTAL_W-1:0]  i_total,
    input logic signed [MEAN1_W-1:0]  i_mean_x,
    input logic        [MEANSQ_W-1:0] i_mean_xx
);

    // A stalled result transaction keeps its valid and its payload, checked on status and total.
    `WMA_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid, "result valid dropped while stalled")
    `WMA_ASSERT_NXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(i_status) && $stable(i_total), "result payload changed while stalled")

    // Only one hit is in work at a time.
    `WMA_ASSERT_NXT(a_one_hit, i_clk, i_rst_n, i_hit_valid && i_hit_ready, !i_hit_ready, "hit accepted while another is in work")

    // An accepted step reports emptied exactly when the total is zero, and then mean_x and mean_xx are zero.
    `WMA_ASSERT_IMP(a_empty_total, i_clk, i_rst_n, i_res_valid && (i_status == ST_OK || i_status == ST_EMPTIED), (i_status == ST_EMPTIED) == (i_total == '0), "emptied status disagrees with total")
    `WMA_ASSERT_IMP(a_empty_means, i_clk, i_rst_n, i_res_valid && (i_status == ST_EMPTIED), (i_mean_x == '0) && (i_mean_xx == '0), "means not cleared on empty track")

endmodule

bind weighted_moment_accumulator wma_checker u_wma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_hit_valid (i_hit.valid),
    .i_hit_ready (i_hit.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_total     (o_res.total_weight),
    .i_mean_x    (o_res.mean_x),
    .i_mean_xx   (o_res.mean_xx)
);

@@ verif/weighted_moment_accumulator_test.sv @@
// Self-checking testbench of the weighted moment accumulator: directed hits, then random tracks.
// A local track model predicts every result, which is compared field by field with the output.
// Depends on wma_pkg, the handshake interfaces in wma_if.sv and the accumulator itself.
`timescale 1ns / 1ps

module weighted_moment_accumulator_test;
    import wma_pkg::*;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam int RANDOM_HITS  = 1200;
    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 700;
    localparam int IDLE_PERCENT = 37;

    typedef struct packed {
        t_status                    status;
        logic        [TOTAL_W-1:0]  total_weight;
        logic signed [MEAN1_W-1:0]  mean_x;
        logic signed [MEAN1_W-1:0]  mean_y;
        logic signed [MEAN1_W-1:0]  mean_z;
        logic        [MEANSQ_W-1:0] mean_xx;
        logic        [MEANSQ_W-1:0] mean_yy;
        logic        [MEANSQ_W-1:0] mean_zz;
        logic signed [MEANX_W-1:0]  mean_xy;
        logic signed [MEANX_W-1:0]  mean_yz;
        logic signed [MEANX_W-1:0]  mean_zx;
    } moment_result_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic        [15:0] w;
    } track_hit_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic        [15:0] w;
        logic               typed;
        t_status            st;
        logic [TOTAL_W-1:0] tot;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    // The add overflow refusal needs some 65,000 full-weight adds and lies beyond this run.
    localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        '{OP_REMOVE,      0,      0,      0,     1, 1'b1, ST_REM_REFUSED,      0},
        '{OP_ADD,     32767,     -1,      0,     0, 1'b1, ST_EMPTIED,          0},
        '{OP_ADD,     32767, -32768,      0, 65535, 1'b1, ST_OK,           65535},
        '{OP_ADD,    -32768,  32767,     -1, 65535, 1'b1, ST_OK,          131070},
        '{OP_ADD,      1234,  -5678,      9,     0, 1'b1, ST_OK,          131070},
        '{OP_REMOVE, -32768,  32767,     -1, 65535, 1'b1, ST_OK,           65535},
        '{OP_REMOVE,  32767, -32768,      0, 65535, 1'b1, ST_EMPTIED,          0},
        '{OP_ADD,    -32768, -32768, -32768,     1, 1'b1, ST_OK,               1},
        '{OP_REMOVE,      0,      0,      0,     2, 1'b1, ST_REM_REFUSED,      1},
        '{OP_REMOVE,      5,      5,      5,     0, 1'b1, ST_OK,               1},
        '{OP_ADD,     32767,  32767,  32767, 65535, 1'b1, ST_OK,           65536},
        '{OP_REMOVE, -32768, -32768, -32768,     1, 1'b1, ST_OK,           65535},
        '{OP_REMOVE,  32767,  32767,  32767, 65535, 1'b1, ST_EMPTIED,          0},
        '{OP_ADD,         0,      0,      0,     1, 1'b1, ST_OK,               1},
        '{OP_ADD,         0,      0,      0, 65535, 1'b1, ST_OK,           65536},
        '{OP_REMOVE, -32768,  32767, -32768, 65535, 1'b0, ST_OK,               0},
        '{OP_REMOVE,      1,      2,      3, 65535, 1'b1, ST_REM_REFUSED,      1},
        '{OP_REMOVE,      7,      7,      7,     1, 1'b1, ST_EMPTIED,          0},
        '{OP_ADD,        -1,      1,     -1, 65535, 1'b1, ST_OK,           65535},
        '{OP_ADD,       100,   -200,    300, 65535, 1'b1, ST_OK,          131070},
        '{OP_ADD,    -32768,      0,  32767, 40000, 1'b0, ST_OK,               0},
        '{OP_REMOVE,     -1,      1,     -1, 65535, 1'b0, ST_OK,               0}
    };

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   mismatches;
    int   stray_results;
    int   quiet_cycles;

    logic [TOTAL_W-1:0] trk_total;
    longint             trk_first  [3];
    longint             trk_square [3];
    longint             trk_cross  [3];

    moment_result_t pending_results [$];
    track_hit_t     track_hits [$];

    wma_hit_if #(.POS_BITS(16), .WEIGHT_BITS(16)) hit_ch ();
    wma_res_if res_ch ();

    weighted_moment_accumulator #(
        .POS_BITS    (16),
        .WEIGHT_BITS (16)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hit   (hit_ch.sink),
        .o_res   (res_ch.source)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint mean_update(input longint mean, input longint term,
                                           input logic [31:0] tot, input logic [31:0] w,
                                           input bit sub, input logic [31:0] new_tot,
                                           input longint unsigned pos_lim,
                                           input longint unsigned neg_lim);
        bit                  sa;
        bit                  sb;
        bit                  sr;
        logic [63:0]         ma;
        logic [63:0]         mb;
        logic [127:0]        a;
        logic [127:0]        b;
        logic [127:0]        num;
        logic [127:0]        quo;
        longint unsigned     lim;
        sa  = mean < 0;
        sb  = term < 0;
        ma  = sa ? 64'(-mean) : 64'(mean);
        mb  = sb ? 64'(-term) : 64'(term);
        a   = 128'(ma) * 128'(tot);
        b   = 128'(mb) * 128'(w);
        if (sub) begin
            sb = !sb;
        end
        if (sa == sb) begin
            num = a + b;
            sr  = sa;
        end else if (a >= b) begin
            num = a - b;
            sr  = sa;
        end else begin
            num = b - a;
            sr  = sb;
        end
        quo = num / 128'(new_tot);
        lim = sr ? neg_lim : pos_lim;
        if (quo > 128'(lim)) begin
            quo = 128'(lim);
        end
        return sr ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic moment_result_t track_step(input logic removing,
                                                  input logic signed [15:0] px,
                                                  input logic signed [15:0] py,
                                                  input logic signed [15:0] pz,
                                                  input logic [15:0] w);
        moment_result_t     res;
        longint             p [3];
        logic [TOTAL_W-1:0] tot;
        logic [TOTAL_W-1:0] new_tot;
        logic [TOTAL_W:0]   sum;
        int                 j;
        p[0] = longint'(px);
        p[1] = longint'(py);
        p[2] = longint'(pz);
        tot  = trk_total;
        sum  = {1'b0, tot} + 33'(w);
        if (removing && 32'(w) > tot) begin
            res.status = ST_REM_REFUSED;
        end else if (!removing && sum[TOTAL_W]) begin
            res.status = ST_ADD_REFUSED;
        end else begin
            new_tot = removing ? tot - 32'(w) : sum[TOTAL_W-1:0];
            if (new_tot == 0) begin
                res.status = ST_EMPTIED;
                trk_total  = '0;
                for (int i = 0; i < 3; i++) begin
                    trk_first[i]  = 0;
                    trk_square[i] = 0;
                    trk_cross[i]  = 0;
                end
            end else begin
                res.status = ST_OK;
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    trk_first[i]  = mean_update(trk_first[i], p[i], tot, 32'(w), removing,
                                                new_tot, 64'(LIM1_POS), 64'(LIM1_NEG));
                    trk_square[i] = mean_update(trk_square[i], p[i] * p[i], tot, 32'(w),
                                                removing, new_tot, 64'(LIMSQ_POS),
                                                64'(LIMSQ_NEG));
                    trk_cross[i]  = mean_update(trk_cross[i], p[i] * p[j], tot, 32'(w),
                                                removing, new_tot, 64'(LIMX_POS),
                                                64'(LIMX_NEG));
                end
                trk_total = new_tot;
            end
        end
        res.total_weight = trk_total;
        res.mean_x  = trk_first[0][MEAN1_W-1:0];
        res.mean_y  = trk_first[1][MEAN1_W-1:0];
        res.mean_z  = trk_first[2][MEAN1_W-1:0];
        res.mean_xx = trk_square[0][MEANSQ_W-1:0];
        res.mean_yy = trk_square[1][MEANSQ_W-1:0];
        res.mean_zz = trk_square[2][MEANSQ_W-1:0];
        res.mean_xy = trk_cross[0][MEANX_W-1:0];
        res.mean_yz = trk_cross[1][MEANX_W-1:0];
        res.mean_zx = trk_cross[2][MEANX_W-1:0];
        return res;
    endfunction

    function automatic logic signed [15:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return 16'sh8000;
        end else if (r < 10) begin
            return 16'sh7FFF;
        end else if (r < 13) begin
            return 16'sh0000;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return 16'h0000;
        end else if (r < 15) begin
            return 16'hFFFF;
        end else if (r < 40) begin
            return 16'($urandom_range(1, 255));
        end
        return 16'($urandom);
    endfunction

    function automatic track_hit_t pick_hit();
        track_hit_t h;
        h.x = pick_pos();
        h.y = pick_pos();
        h.z = pick_pos();
        h.w = pick_weight();
        return h;
    endfunction

    task automatic send_hit(input logic kind, input track_hit_t h, input bit typed,
                            input t_status typed_st, input logic [TOTAL_W-1:0] typed_tot,
                            output t_status pred_st);
        moment_result_t exp_res;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            hit_ch.valid <= 1'b0;
            @(negedge clk);
        end
        hit_ch.valid  <= 1'b1;
        hit_ch.kind   <= kind;
        hit_ch.pos_x  <= h.x;
        hit_ch.pos_y  <= h.y;
        hit_ch.pos_z  <= h.z;
        hit_ch.weight <= h.w;
        do begin
            @(posedge clk);
        end while (!hit_ch.ready);
        exp_res = track_step(kind, h.x, h.y, h.z, h.w);
        if (typed) begin
            exp_res.status       = typed_st;
            exp_res.total_weight = typed_tot;
        end
        pred_st = exp_res.status;
        pending_results = {pending_results, exp_res};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        hit_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v,
                               inout bit bad);
        if (exp_v != act_v) begin
            bad = 1'b1;
            if (mismatches < 10) begin
                $display("mismatch on %s: expected %0d, actual %0d", name, exp_v, act_v);
            end
        end
    endtask

    task automatic check_result(input moment_result_t exp_r, input moment_result_t act_r);
        bit bad;
        bad = 1'b0;
        check_field("status", longint'(exp_r.status), longint'(act_r.status), bad);
        check_field("total_weight", longint'(exp_r.total_weight),
                    longint'(act_r.total_weight), bad);
        check_field("mean_x", longint'(exp_r.mean_x), longint'(act_r.mean_x), bad);
        check_field("mean_y", longint'(exp_r.mean_y), longint'(act_r.mean_y), bad);
        check_field("mean_z", longint'(exp_r.mean_z), longint'(act_r.mean_z), bad);
        check_field("mean_xx", longint'(exp_r.mean_xx), longint'(act_r.mean_xx), bad);
        check_field("mean_yy", longint'(exp_r.mean_yy), longint'(act_r.mean_yy), bad);
        check_field("mean_zz", longint'(exp_r.mean_zz), longint'(act_r.mean_zz), bad);
        check_field("mean_xy", longint'(exp_r.mean_xy), longint'(act_r.mean_xy), bad);
        check_field("mean_yz", longint'(exp_r.mean_yz), longint'(act_r.mean_yz), bad);
        check_field("mean_zx", longint'(exp_r.mean_zx), longint'(act_r.mean_zx), bad);
        if (bad) begin
            mismatches++;
        end
    endtask

    always @(negedge clk) begin
        res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge clk) begin
        moment_result_t got;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.status       = res_ch.status;
                got.total_weight = res_ch.total_weight;
                got.mean_x       = res_ch.mean_x;
                got.mean_y       = res_ch.mean_y;
                got.mean_z       = res_ch.mean_z;
                got.mean_xx      = res_ch.mean_xx;
                got.mean_yy      = res_ch.mean_yy;
                got.mean_zz      = res_ch.mean_zz;
                got.mean_xy      = res_ch.mean_xy;
                got.mean_yz      = res_ch.mean_yz;
                got.mean_zx      = res_ch.mean_zx;
                if (pending_results.size() == 0) begin
                    stray_results++;
                    if (mismatches + stray_results <= 10) begin
                        $display("result transaction with no expectation waiting");
                    end
                end else begin
                    check_result(pending_results.pop_front(), got);
                end
            end
            if ((res_ch.valid && res_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial begin
        int         sel;
        int         idx;
        int         draining;
        track_hit_t h;
        t_status    st_pred;

        rst_n         = 1'b0;
        no_idle       = 1'b0;
        mismatches    = 0;
        stray_results = 0;
        quiet_cycles  = 0;
        draining      = 0;
        trk_total     = '0;
        for (int i = 0; i < 3; i++) begin
            trk_first[i]  = 0;
            trk_square[i] = 0;
            trk_cross[i]  = 0;
        end
        hit_ch.valid  = 1'b0;
        hit_ch.kind   = OP_ADD;
        hit_ch.pos_x  = '0;
        hit_ch.pos_y  = '0;
        hit_ch.pos_z  = '0;
        hit_ch.weight = '0;
        res_ch.ready  = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++) begin
            h = '{DIR_TABLE[k].x, DIR_TABLE[k].y, DIR_TABLE[k].z, DIR_TABLE[k].w};
            send_hit(DIR_TABLE[k].kind, h, DIR_TABLE[k].typed, DIR_TABLE[k].st,
                     DIR_TABLE[k].tot, st_pred);
        end
        wait_drained();

        // Mostly genuine tracks: hits are added, then removed again in any order, and now and
        // then a whole track is drained to empty; the rest are removals of unknown hits.
        for (int n = 0; n < RANDOM_HITS; n++) begin
            no_idle = (n >= 300) && (n < 450);
            if (n == 600) begin
                wait_drained();
            end
            sel = $urandom_range(0, 99);
            if (draining == 0 && track_hits.size() > 0 && sel < 3) begin
                draining = track_hits.size();
            end
            if (sel >= 88 && draining == 0) begin
                send_hit(OP_REMOVE, pick_hit(), 1'b0, ST_OK, '0, st_pred);
            end else if (track_hits.size() > 0 &&
                         (draining > 0 || sel < 45 || track_hits.size() >= 24)) begin
                idx = (draining > 0) ? 0 : $urandom_range(0, track_hits.size() - 1);
                h   = track_hits[idx];
                track_hits.delete(idx);
                if (draining > 0) begin
                    draining--;
                end
                send_hit(OP_REMOVE, h, 1'b0, ST_OK, '0, st_pred);
            end else begin
                h = pick_hit();
                track_hits = {track_hits, h};
                send_hit(OP_ADD, h, 1'b0, ST_OK, '0, st_pred);
            end
            if (st_pred == ST_EMPTIED) begin
                track_hits.delete();
                draining = 0;
            end
        end

        @(negedge clk);
        hit_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0 && stray_results == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/wma_pkg.sv
sv/wma_if.sv
sv/wma_serial_mul.sv
sv/wma_serial_div.sv
sv/weighted_moment_accumulator.sv
sv/wma_checker.sv
verif/weighted_moment_accumulator_test.sv
